// ===== design/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// shared types and constants of the response checker
// ----------------------------------------------------------------------------
package hrc_pkg;

   localparam int BODY_DEPTH = 4096;
   localparam int COUNT_BITS = 32;
   localparam int LEN_BITS = 13;
   localparam int VAL_BITS = 31;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SHORT  = 2'd1,
      ST_FORMAT = 2'd2,
      ST_SIZE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2,
      PH_BAD    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      VS_SPACES = 2'd0,
      VS_DIGITS = 2'd1,
      VS_DONE   = 2'd2
   } vstage_type;

   // classified work handed from front to back
   typedef struct packed {
      logic       is_load;
      logic [7:0] data;
      logic [11:0] index;
      logic       last;
   } work_type;

   function automatic logic [7:0] status_char(input logic [4:0] i);
      logic [7:0] c;
      unique case (i)
         5'd0: c = "H";  5'd1: c = "T";  5'd2: c = "T";  5'd3: c = "P";
         5'd4: c = "/";  5'd5: c = "1";  5'd6: c = ".";  5'd7: c = "0";
         5'd8: c = " ";  5'd9: c = "2";  5'd10: c = "0"; 5'd11: c = "0";
         5'd12: c = " "; 5'd13: c = "O"; 5'd14: c = "K"; 5'd15: c = 8'h0d;
         5'd16: c = 8'h0a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [3:0] i);
      logic [7:0] c;
      unique case (i)
         4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
         4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
         4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
         4'd12: c = "t"; 4'd13: c = "h"; 4'd14: c = ":";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== design/hrc_front.sv =====
// ----------------------------------------------------------------------------
// hrc_front
// request intake and small work queue
// ----------------------------------------------------------------------------
module hrc_front #(
   parameter int DEPTH = hrc_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [7:0]        req_byte_value,
   input  logic [11:0]       req_load_index,
   input  logic              req_last,
   output logic              wq_valid,
   input  logic              wq_ready,
   output hrc_pkg::work_type wq_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   hrc_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push = req_valid && req_ready;
   assign wq_valid = (cnt_ff != '0);
   assign pop = wq_valid && wq_ready;
   assign wq_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{is_load: !req_opcode, data: req_byte_value,
                            index: req_load_index, last: req_last};
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == (AW+1)'(DEPTH)) |-> !req_ready) else $error("ready while full");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> !wq_valid) else $error("valid while empty");

endmodule

// ===== design/hrc_back.sv =====
// ----------------------------------------------------------------------------
// hrc_back
// response parser, body compare against the expected store, result register
// ----------------------------------------------------------------------------
module hrc_back #(
   parameter int BODY_DEPTH = hrc_pkg::BODY_DEPTH,
   parameter int COUNT_BITS = hrc_pkg::COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [hrc_pkg::LEN_BITS-1:0]    exp_len,
   input  logic                            wq_valid,
   output logic                            wq_ready,
   input  hrc_pkg::work_type               wq_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [hrc_pkg::VAL_BITS-1:0]    rsp_content_length,
   output logic                            rsp_length_seen
);
   localparam int BA = $clog2(BODY_DEPTH);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [31:0] VMAX = 32'h7fff_ffff;

   // stage 1: store read; the body compare happens in the cycle after
   logic [7:0] store_ff [BODY_DEPTH];
   logic [7:0] rd_data_ff;
   logic       cmp_ff, cmp_in;
   logic [7:0] cmp_byte_ff;
   logic       zero_ff;          // body index past the store compares with zero
   logic       fin_ff, fin_in;   // a last byte waits for the compare stage

   logic [COUNT_BITS-1:0] pos_ff, pos_in, bcnt_ff, bcnt_in;
   logic [31:0] recent_ff, recent_in;
   hrc_pkg::phase_type phase_ff, phase_in;
   logic [4:0] loff_ff, loff_in;
   logic pm_ff, pm_in, hs_ff, hs_in, pr_ff, pr_in, mis_ff, mis_in;
   logic [hrc_pkg::VAL_BITS-1:0] acc_ff, acc_in;
   hrc_pkg::vstage_type vs_ff, vs_in;
   logic [1:0] ferr_ff, ferr_in;

   logic rv_ff;
   logic [1:0] rst_ff;
   logic [hrc_pkg::VAL_BITS-1:0] rcl_ff;
   logic rls_ff;

   logic take, rsp_item, fire;
   logic [7:0] b;
   logic [BA-1:0] rd_addr;
   logic in_store;
   logic [1:0] st_c;
   logic seen_c, mis_now;

   // no byte is taken in the finish cycle; the finish waits while an
   // earlier verdict is still held in the result register
   assign fire = fin_ff && (!rv_ff || rsp_ready);
   assign wq_ready = !fin_ff;
   assign take = wq_valid && wq_ready;
   assign rsp_item = take && !wq_data.is_load;
   assign b = wq_data.data;
   assign in_store = (bcnt_ff < COUNT_BITS'(BODY_DEPTH));
   assign rd_addr = bcnt_ff[BA-1:0];

   always_ff @(posedge clock) begin
      if (take && wq_data.is_load && (32'(wq_data.index) < 32'(BODY_DEPTH)))
         store_ff[wq_data.index[BA-1:0]] <= wq_data.data;
      rd_data_ff <= store_ff[rd_addr];
   end

   // content character step, may run twice for a lone cr
   function automatic void content_char(input logic [7:0] c,
         inout logic [4:0] lo, inout logic pm, inout logic hs,
         inout logic [1:0] fe, inout hrc_pkg::vstage_type vs,
         inout logic [hrc_pkg::VAL_BITS-1:0] acc);
      logic dig;
      logic [34:0] v;
      dig = (c >= "0") && (c <= "9");
      v = 35'(acc) * 35'd10 + 35'(c - "0");
      if (fe == 2'd0) begin
         if (lo < 5'd15) begin
            if (c != hrc_pkg::prefix_char(lo[3:0])) pm = 1'b0;
         end else if (pm) begin
            if (lo == 5'd15) begin
               if (hs) fe = hrc_pkg::ST_FORMAT;
               else hs = 1'b1;
            end
            if (fe == 2'd0) begin
               if (vs == hrc_pkg::VS_SPACES) begin
                  if (c != " ") begin
                     if (!dig) fe = hrc_pkg::ST_FORMAT;
                     else begin
                        acc = hrc_pkg::VAL_BITS'(c - "0");
                        vs = hrc_pkg::VS_DIGITS;
                     end
                  end
               end else if (vs == hrc_pkg::VS_DIGITS) begin
                  if (!dig) fe = hrc_pkg::ST_FORMAT;
                  else if (v > 35'(VMAX)) fe = hrc_pkg::ST_SIZE;
                  else acc = v[hrc_pkg::VAL_BITS-1:0];
               end
            end
         end
      end
      if (lo < 5'd16) lo = lo + 5'd1;
   endfunction

   always_comb begin
      pos_in = pos_ff; bcnt_in = bcnt_ff; recent_in = recent_ff; phase_in = phase_ff;
      loff_in = loff_ff; pm_in = pm_ff; hs_in = hs_ff; pr_in = pr_ff;
      acc_in = acc_ff; vs_in = vs_ff; ferr_in = ferr_ff;
      cmp_in = 1'b0; fin_in = fin_ff;
      if (rsp_item) begin
         unique case (phase_ff)
            hrc_pkg::PH_STATUS: begin
               if (b != hrc_pkg::status_char(pos_ff[4:0])) phase_in = hrc_pkg::PH_BAD;
               else if (pos_ff[4:0] == 5'd16) phase_in = hrc_pkg::PH_HEADER;
            end
            hrc_pkg::PH_HEADER: begin
               if (pr_ff) begin
                  if (b == 8'h0a) begin
                     pr_in = 1'b0;
                     if (ferr_in == 2'd0 && pm_in && loff_in > 5'd15) begin
                        if (vs_in == hrc_pkg::VS_SPACES) ferr_in = hrc_pkg::ST_FORMAT;
                        else if (vs_in == hrc_pkg::VS_DIGITS) vs_in = hrc_pkg::VS_DONE;
                     end
                     loff_in = '0; pm_in = 1'b1;
                  end else begin
                     content_char(8'h0d, loff_in, pm_in, hs_in, ferr_in, vs_in, acc_in);
                     if (b == 8'h0d) pr_in = 1'b1;
                     else begin
                        pr_in = 1'b0;
                        content_char(b, loff_in, pm_in, hs_in, ferr_in, vs_in, acc_in);
                     end
                  end
               end else if (b == 8'h0d) pr_in = 1'b1;
               else content_char(b, loff_in, pm_in, hs_in, ferr_in, vs_in, acc_in);
               recent_in = {recent_ff[23:0], b};
               if (recent_in == 32'h0d0a0d0a) phase_in = hrc_pkg::PH_BODY;
            end
            hrc_pkg::PH_BODY: begin
               cmp_in = (bcnt_ff < COUNT_BITS'(exp_len));
               if (bcnt_ff != CMAX) bcnt_in = bcnt_ff + 1'b1;
            end
            default: ;
         endcase
         if (pos_ff != CMAX) pos_in = pos_ff + 1'b1;
         fin_in = wq_data.last;
      end
   end

   assign mis_now = cmp_ff && (cmp_byte_ff != (zero_ff ? 8'h00 : rd_data_ff));
   assign mis_in = mis_ff || mis_now;

   // final verdict, built from the state after the compare stage settles
   always_comb begin
      if (pos_ff < COUNT_BITS'(17)) st_c = hrc_pkg::ST_SHORT;
      else if (phase_ff == hrc_pkg::PH_BAD) st_c = hrc_pkg::ST_FORMAT;
      else if (phase_ff != hrc_pkg::PH_BODY) st_c = hrc_pkg::ST_SIZE;
      else if (ferr_ff != 2'd0) st_c = ferr_ff;
      else if (vs_ff != hrc_pkg::VS_DONE || 32'(acc_ff) != 32'(exp_len))
         st_c = hrc_pkg::ST_FORMAT;
      else if (32'(bcnt_ff) != 32'(acc_ff)) st_c = hrc_pkg::ST_SIZE;
      else if (mis_in) st_c = hrc_pkg::ST_FORMAT;
      else st_c = hrc_pkg::ST_OK;
      seen_c = (phase_ff == hrc_pkg::PH_BODY) && (vs_ff == hrc_pkg::VS_DONE);
   end

   always_ff @(posedge clock) begin
      cmp_byte_ff <= b;
      zero_ff <= !in_store;
      if (fire) begin
         rst_ff <= st_c;
         rcl_ff <= seen_c ? acc_ff : '0;
         rls_ff <= seen_c;
      end
   end

   // a stream reset lands when the finish stage fires; no byte is taken then
   always_ff @(posedge clock) begin
      if (reset || fire) begin
         pos_ff <= '0; bcnt_ff <= '0; recent_ff <= '0; phase_ff <= hrc_pkg::PH_STATUS;
         loff_ff <= '0; pm_ff <= 1'b1; hs_ff <= 1'b0; pr_ff <= 1'b0;
         acc_ff <= '0; vs_ff <= hrc_pkg::VS_SPACES; ferr_ff <= '0; mis_ff <= 1'b0;
         cmp_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in; bcnt_ff <= bcnt_in; recent_ff <= recent_in; phase_ff <= phase_in;
         loff_ff <= loff_in; pm_ff <= pm_in; hs_ff <= hs_in; pr_ff <= pr_in;
         acc_ff <= acc_in; vs_ff <= vs_in; ferr_ff <= ferr_in; mis_ff <= mis_in;
         cmp_ff <= cmp_in; fin_ff <= fin_in;
      end
      if (reset) rv_ff <= 1'b0;
      else if (fire) rv_ff <= 1'b1;
      else if (rsp_ready) rv_ff <= 1'b0;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_content_length = rcl_ff;
   assign rsp_length_seen = rls_ff;

   a_no_take_at_fin: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> !take) else $error("byte taken during finish");
   a_fin_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fin_ff |=> rsp_valid) else $error("finish without result");
   a_seen_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_length_seen) |-> (rsp_content_length == '0))
      else $error("length without seen");

endmodule

// ===== design/http_response_checker_top.sv =====
// ----------------------------------------------------------------------------
// http_response_checker_top
// http/1.0 response checker with content-length and body compare
// ----------------------------------------------------------------------------
// channel  ports   direction  role
// req_     valid/ready  in   load byte or response byte
// rsp_     valid/ready  out  one verdict per last response byte
// csr_     we/wdata     in   expected body length
// the parser takes one request per cycle from a four-entry queue; a last
// response byte adds a finish step in which the parser takes nothing
// (store read and body compare run one stage behind).
// the finish also waits while an earlier verdict is still held on rsp_.
// reset is synchronous; the expected store has no reset and is written by
// load requests.
// ----------------------------------------------------------------------------
module http_response_checker_top #(
   parameter int BODY_DEPTH = hrc_pkg::BODY_DEPTH,
   parameter int COUNT_BITS = hrc_pkg::COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_byte_value,
   input  logic [11:0] req_load_index,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [30:0] rsp_content_length,
   output logic        rsp_length_seen,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);
   logic [hrc_pkg::LEN_BITS-1:0] len_ff;
   logic wq_valid, wq_ready;
   hrc_pkg::work_type wq_data;

   always_ff @(posedge clock) begin
      if (reset) len_ff <= '0;
      else if (csr_we) len_ff <= csr_wdata;
   end

   hrc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_byte_value,
      .req_load_index, .req_last, .wq_valid, .wq_ready, .wq_data
   );

   hrc_back #(.BODY_DEPTH(BODY_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .exp_len(len_ff), .wq_valid, .wq_ready, .wq_data,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_content_length, .rsp_length_seen
   );

endmodule

// ===== verif/http_response_checker_top_tb.sv =====
// ----------------------------------------------------------------------------
// http_response_checker_top_tb
// drives load and response bytes through the checker, predicts each verdict
// with a local parser and body compare, and checks every verdict in order
// ----------------------------------------------------------------------------
module http_response_checker_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      hrc_pkg::status_type status;
      logic [30:0]         clen;
      logic                seen;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [7:0]  req_byte_value;
   logic [11:0] req_load_index;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_content_length;
   logic        rsp_length_seen;
   logic        csr_we;
   logic [12:0] csr_wdata;

   http_response_checker_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_byte_value(req_byte_value), .req_load_index(req_load_index),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_content_length(rsp_content_length), .rsp_length_seen(rsp_length_seen),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // predictor state
   logic [7:0]  body_mem [hrc_pkg::BODY_DEPTH];
   logic [12:0] want_len;
   int unsigned pos;
   logic [31:0] tail4;
   hrc_pkg::phase_type  ph;
   int unsigned line_off;
   logic        pfx_ok;
   logic        hdr_seen;
   logic [30:0] acc;
   hrc_pkg::vstage_type vst;
   logic        cr_wait;
   logic [1:0]  hdr_err;
   int unsigned body_cnt;
   logic        body_bad;

   verdict_type verdicts_due [$];
   int          mismatches = 0;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_rsp = 1'b0;
   int          idle_cycles = 0;
   int          hold_requests = 0;
   int          hold_served = 0;

   string status_line = "HTTP/1.0 200 OK\r\n";
   string prefix_text = "Content-Length:";

   function automatic void clear_stream();
      pos = 0; tail4 = '0; ph = hrc_pkg::PH_STATUS; line_off = 0; pfx_ok = 1'b1;
      hdr_seen = 1'b0; acc = '0; vst = hrc_pkg::VS_SPACES; cr_wait = 1'b0;
      hdr_err = hrc_pkg::ST_OK; body_cnt = 0; body_bad = 1'b0;
   endfunction

   function automatic void value_char(logic [7:0] b);
      logic        dig;
      logic [34:0] v;
      dig = (b >= "0" && b <= "9");
      if (vst == hrc_pkg::VS_SPACES) begin
         if (b == " ") return;
         if (!dig) begin
            hdr_err = hrc_pkg::ST_FORMAT;
            return;
         end
         acc = 31'(b - "0");
         vst = hrc_pkg::VS_DIGITS;
      end else if (vst == hrc_pkg::VS_DIGITS) begin
         if (!dig) begin
            hdr_err = hrc_pkg::ST_FORMAT;
            return;
         end
         v = 35'(acc) * 10 + 35'(b - "0");
         if (v > 35'h7fffffff) begin
            hdr_err = hrc_pkg::ST_SIZE;
            return;
         end
         acc = v[30:0];
      end
   endfunction

   function automatic void line_char(logic [7:0] b);
      if (hdr_err == hrc_pkg::ST_OK) begin
         if (line_off < 15) begin
            if (b != prefix_text[line_off]) pfx_ok = 1'b0;
         end else if (pfx_ok) begin
            if (line_off == 15) begin
               if (hdr_seen) hdr_err = hrc_pkg::ST_FORMAT;
               else hdr_seen = 1'b1;
            end
            if (hdr_err == hrc_pkg::ST_OK) value_char(b);
         end
      end
      if (line_off < 16) line_off++;
   endfunction

   function automatic void header_byte(logic [7:0] b);
      if (cr_wait) begin
         if (b == 8'h0a) begin
            cr_wait = 1'b0;
            if (hdr_err == hrc_pkg::ST_OK && pfx_ok && line_off > 15) begin
               if (vst == hrc_pkg::VS_SPACES) hdr_err = hrc_pkg::ST_FORMAT;
               else if (vst == hrc_pkg::VS_DIGITS) vst = hrc_pkg::VS_DONE;
            end
            line_off = 0;
            pfx_ok = 1'b1;
         end else begin
            line_char(8'h0d);
            if (b == 8'h0d) cr_wait = 1'b1;
            else begin
               cr_wait = 1'b0;
               line_char(b);
            end
         end
      end else if (b == 8'h0d) cr_wait = 1'b1;
      else line_char(b);
      tail4 = {tail4[23:0], b};
      if (tail4 == 32'h0d0a0d0a) ph = hrc_pkg::PH_BODY;
   endfunction

   // returns 1 when the byte produces a verdict
   function automatic bit predict_verdict(logic op, logic [7:0] b, logic [11:0] idx,
                                          logic lst, output verdict_type r);
      logic seen;
      r = '{hrc_pkg::ST_OK, '0, 1'b0};
      if (!op) begin
         body_mem[idx] = b;
         return 0;
      end
      case (ph)
         hrc_pkg::PH_STATUS: begin
            if (pos < 17 && b != status_line[pos]) ph = hrc_pkg::PH_BAD;
            else if (pos == 16) ph = hrc_pkg::PH_HEADER;
         end
         hrc_pkg::PH_HEADER: header_byte(b);
         hrc_pkg::PH_BODY: begin
            if (body_cnt < want_len) begin
               if (b != (body_cnt < hrc_pkg::BODY_DEPTH ? body_mem[body_cnt] : 8'h00))
                  body_bad = 1'b1;
            end
            if (body_cnt != 32'hffffffff) body_cnt++;
         end
         default: ;
      endcase
      if (pos != 32'hffffffff) pos++;
      if (!lst) return 0;
      if (pos < 17) r.status = hrc_pkg::ST_SHORT;
      else if (ph == hrc_pkg::PH_BAD) r.status = hrc_pkg::ST_FORMAT;
      else if (ph != hrc_pkg::PH_BODY) r.status = hrc_pkg::ST_SIZE;
      else if (hdr_err != hrc_pkg::ST_OK) r.status = hrc_pkg::status_type'(hdr_err);
      else if (vst != hrc_pkg::VS_DONE || 32'(acc) != 32'(want_len))
         r.status = hrc_pkg::ST_FORMAT;
      else if (body_cnt != 32'(acc)) r.status = hrc_pkg::ST_SIZE;
      else if (body_bad) r.status = hrc_pkg::ST_FORMAT;
      else r.status = hrc_pkg::ST_OK;
      seen = (ph == hrc_pkg::PH_BODY && vst == hrc_pkg::VS_DONE);
      r.clen = seen ? acc : '0;
      r.seen = seen;
      clear_stream();
      return 1;
   endfunction

   // valid stays up between requests unless the sender idles
   task automatic send_byte(logic op, logic [7:0] b, logic [11:0] idx, logic lst);
      verdict_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_byte_value <= b;
      req_load_index <= idx;
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (predict_verdict(op, b, idx, lst, r)) verdicts_due.push_back(r);
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit lst);
      for (int i = 0; i < s.len(); i++)
         send_byte(1'b1, s[i], 12'($urandom), lst && i == s.len() - 1);
   endtask

   task automatic load_body(int n);
      for (int i = 0; i < n; i++)
         send_byte(1'b0, 8'($urandom), 12'(i), 1'($urandom));
   endtask

   // body bytes taken from the predictor's own store copy
   task automatic send_body(int n, bit corrupt);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = (i < hrc_pkg::BODY_DEPTH) ? body_mem[i] : 8'h00;
         if (corrupt && i == n - 1) b = ~b;
         send_byte(1'b1, b, 12'($urandom), i == n - 1);
      end
   endtask

   task automatic drain_and_write_len(logic [12:0] v);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      want_len = v;
   endtask

   // header with given length text and body; body count n is the actual length
   task automatic send_response(string len_txt, int n, bit corrupt);
      send_text(status_line, 0);
      send_text({"Server: x\r\n", "Content-Length:", len_txt, "\r\n\r\n"}, n == 0);
      if (n > 0) send_body(n, corrupt);
   endtask

   task automatic test_directed();
      drain_and_write_len(13'd4);
      load_body(4);
      send_response(" 4", 4, 0);
      send_response("4", 4, 1);
      send_response("4", 3, 0);
      send_response("  ", 4, 0);
      send_response("4x", 4, 0);
      send_response("99999999999", 4, 0);
      send_response("5", 5, 0);
      send_text("HTTP/1.0", 1);
      send_text("HTTP/1.1 200 OK\r\nX", 1);
      send_text({status_line, "A: b\r\n"}, 1);
      send_text({status_line, "Content-Length:4\r\nContent-Length:4\r\n\r\n"}, 0);
      send_body(4, 0);
      send_text({status_line, "\r\n\r\n"}, 1);
      send_byte(1'b1, 8'hff, 12'hfff, 1'b1);
      drain_and_write_len(13'd0);
      send_response("0", 0, 0);
      drain_and_write_len(13'd64);
      load_body(64);
      send_response("64", 64, 0);
      send_byte(1'b0, 8'h00, 12'hfff, 1'b1);
   endtask

   task automatic test_random(int n_items);
      int sent;
      int n;
      int kind;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(9);
         n = $urandom_range(0, 8);
         if (kind == 0) begin
            drain_and_write_len(13'($urandom_range(0, 8)));
            load_body(8);
            sent += 8;
         end else if (kind < 7) begin
            send_response($sformatf("%s%0d", (kind & 1) ? " " : "",
                          kind == 2 ? n : want_len), kind == 3 ? n : want_len,
                          kind == 4);
            sent += 40 + want_len;
         end else begin
            for (int i = 0; i < n + 1; i++)
               send_byte(1'b1, ($urandom_range(0, 3) == 0) ? 8'h0d : 8'($urandom),
                         12'($urandom), i == n);
            sent += n + 1;
         end
      end
   endtask

   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 12; i++) send_byte(1'b1, 8'($urandom), 12'($urandom), 1'b1);
   endtask

   // long receiver hold, counted in its own process
   always @(posedge clock) begin
      if (hold_rsp) begin
         if (idle_cycles == 299) hold_rsp <= 1'b0;
         idle_cycles <= idle_cycles + 1;
      end else if (hold_served != hold_requests) begin
         hold_rsp <= 1'b1;
         hold_served <= hold_requests;
         idle_cycles <= 0;
      end
   end

   always @(negedge clock)
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict status %0d", rsp_status);
         end else begin
            e = verdicts_due.pop_front();
            if (rsp_status !== e.status || rsp_content_length !== e.clen ||
                rsp_length_seen !== e.seen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("verdict mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                           e.status, e.clen, e.seen, rsp_status,
                           rsp_content_length, rsp_length_seen);
            end
         end
      end
   end

   int stuck = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) stuck <= 0;
      else if (stuck >= 20000) begin
         $display("http_response_checker_top_tb: errors");
         $finish;
      end else stuck <= stuck + 1;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_opcode = 1'b0; req_byte_value = '0;
      req_load_index = '0; req_last = 1'b0;
      csr_we = 1'b0; csr_wdata = '0;
      send_idle_pct = 15; recv_idle_pct = 82;
      want_len = '0;
      foreach (body_mem[i]) body_mem[i] = 8'h00;
      clear_stream();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(400);
      send_idle_pct = 82; recv_idle_pct = 15;
      test_backpressure();
      test_random(400);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(400);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0)
         $display("http_response_checker_top_tb: clean");
      else
         $display("http_response_checker_top_tb: errors");
      $finish;
   end

endmodule
